### rtl/fshp_pkg.sv
// Package for the flap stepper homing positioner.
// Holds widths, codes and the phase type for the core, its checker and its testbench.
// Depends on nothing.
package fshp_pkg;

  localparam int Cards   = 64;
  localparam int PosW    = 12;
  localparam int StepW   = 13;
  localparam int IdxW    = 8;
  localparam int ActW    = 2;
  localparam int CfgIdxW = 1;
  localparam int HomW    = $clog2((1 << IdxW) / Cards + 1);
  localparam int RedCntW = $clog2(PosW);

  localparam logic [PosW-1:0] MinRev   = PosW'(4);
  localparam logic [PosW-1:0] RevReset = PosW'(2048);
  localparam logic [IdxW:0]   CardsV   = (IdxW + 1)'(Cards);

  typedef enum logic [ActW-1:0] {
    ACT_TICK = 2'd0,
    ACT_MOVE = 2'd1,
    ACT_HOME = 2'd2
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STEPS_PER_REV = 1'b0,
    CFG_BIAS          = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'b001,
    PH_HOMING   = 3'b010,
    PH_STEPPING = 3'b100
  } phase_e;

endpackage

### rtl/flap_stepper_homing_positioner_core.sv
// Flap stepper homing positioner: command decode, homing and stepping control.
// Depends on fshp_pkg for widths, codes and the phase type.
//
//  channel | direction | handshake          | words carried
//  --------+-----------+--------------------+-------------------------------------------
//  in      | input     | in_valid / stall   | action, target_index, switch_level
//  out     | output    | out_valid / stall  | step_pulse, coils_release, busy_res,
//          |           |                    | position, rejected
//  cfg     | input     | cfg_valid / ready  | cfg_index, cfg_data (steps_per_rev, bias)
//
// An accepted word is held in the input register, is worked in a single
// combinational pass and lands in the result register, one word per cycle
// sustained while the output does not stall and no reduction runs. A new word is
// taken while a result waits to be drained, until both registers are full.
// Any configuration write starts a reduction (one remainder bit per cycle)
// of the position and the bias by the revolution length; input is held off during it
// and while cfg_valid is high. Reset clears control state and gives the reset
// registers, already reduced, so no pass runs after reset.
module flap_stepper_homing_positioner_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input words
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [fshp_pkg::ActW-1:0]         action_i,
  input  logic [fshp_pkg::IdxW-1:0]         target_index_i,
  input  logic                              switch_level_i,
  // result words
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              step_pulse_o,
  output logic                              coils_release_o,
  output logic                              busy_res_o,
  output logic [fshp_pkg::PosW-1:0]         position_o,
  output logic                              rejected_o,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fshp_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [fshp_pkg::PosW-1:0]         cfg_data_i
);

  // configuration registers
  logic [fshp_pkg::PosW-1:0]    spr_q, spr_d;
  logic [fshp_pkg::PosW-1:0]    bias_q, bias_d;

  // reduced copies: position and bias modulo the revolution length
  logic [fshp_pkg::PosW-1:0]    pos_mod_q, pos_mod_d;
  logic [fshp_pkg::PosW-1:0]    bias_mod_q, bias_mod_d;

  // reduction sequencer
  logic                         red_busy_q, red_busy_d;
  logic [fshp_pkg::RedCntW-1:0] red_cnt_q, red_cnt_d;
  logic [fshp_pkg::PosW-1:0]    red_pos_q, red_pos_d;
  logic [fshp_pkg::PosW-1:0]    red_bias_q, red_bias_d;

  // control state
  fshp_pkg::phase_e             phase_q, phase_d;
  logic [fshp_pkg::HomW-1:0]    hom_left_q, hom_left_d;
  logic [fshp_pkg::StepW-1:0]   steps_left_q, steps_left_d;
  logic [fshp_pkg::StepW-1:0]   deferred_q, deferred_d;
  logic [fshp_pkg::PosW-1:0]    pos_q, pos_d;
  logic                         prev_sw_q, prev_sw_d;

  // input register
  logic                         in_vld_q, in_vld_d;
  logic [fshp_pkg::ActW-1:0]    act_q;
  logic [fshp_pkg::IdxW-1:0]    idx_q;
  logic                         lvl_q;

  // result register
  logic                         out_vld_q, out_vld_d;
  logic                         res_pulse_q, res_pulse_d;
  logic                         res_rel_q, res_rel_d;
  logic                         res_busy_q, res_busy_d;
  logic [fshp_pkg::PosW-1:0]    res_pos_q;
  logic                         res_rej_q, res_rej_d;

  logic                         cfg_we;
  logic                         in_acc;
  logic                         proc;
  logic [fshp_pkg::PosW-1:0]    rev;

  // working values of the single pass
  logic [fshp_pkg::PosW-1:0]    card_pitch;
  logic [fshp_pkg::IdxW-1:0]    card_one;
  logic [2*fshp_pkg::PosW-1:0]  card_prod;
  logic [fshp_pkg::StepW-1:0]   tgt_sum;
  logic [fshp_pkg::PosW-1:0]    target;
  logic [fshp_pkg::PosW-1:0]    fwd_gap;
  logic [fshp_pkg::StepW-1:0]   pm_inc;
  logic [fshp_pkg::PosW-1:0]    pos_nxt;
  logic [fshp_pkg::HomW-1:0]    hom_dec;
  logic [fshp_pkg::StepW-1:0]   step_dec;

  // reduction step values
  logic [fshp_pkg::StepW-1:0]   rp_sh, rb_sh;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  // revolution length, never below four steps
  assign rev = (spr_q < fshp_pkg::MinRev) ? fshp_pkg::MinRev : spr_q;

  // work the held word when reduction is done and the result slot frees up
  assign proc       = in_vld_q & ~red_busy_q & (~out_vld_q | ~out_stall_i);
  assign in_stall_o = cfg_valid_i | red_busy_q | (in_vld_q & ~proc);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign in_vld_d   = in_acc | (in_vld_q & ~proc);
  assign out_vld_d  = proc | (out_vld_q & out_stall_i);

  // configuration writes and the restoring remainder sequencer
  always_comb begin
    spr_d      = spr_q;
    bias_d     = bias_q;
    red_busy_d = red_busy_q;
    red_cnt_d  = red_cnt_q;
    red_pos_d  = red_pos_q;
    red_bias_d = red_bias_q;
    bias_mod_d = bias_mod_q;

    rp_sh = {red_pos_q, pos_q[red_cnt_q]};
    rb_sh = {red_bias_q, bias_q[red_cnt_q]};
    if (rp_sh >= {1'b0, rev}) begin
      rp_sh = rp_sh - {1'b0, rev};
    end
    if (rb_sh >= {1'b0, rev}) begin
      rb_sh = rb_sh - {1'b0, rev};
    end

    if (red_busy_q) begin
      red_pos_d  = rp_sh[fshp_pkg::PosW-1:0];
      red_bias_d = rb_sh[fshp_pkg::PosW-1:0];
      red_cnt_d  = red_cnt_q - fshp_pkg::RedCntW'(1);
      if (red_cnt_q == '0) begin
        red_busy_d = 1'b0;
        bias_mod_d = rb_sh[fshp_pkg::PosW-1:0];
      end
    end

    // a write restarts the pass from the top bit
    if (cfg_we) begin
      case (fshp_pkg::cfg_idx_e'(cfg_index_i))
        fshp_pkg::CFG_STEPS_PER_REV: spr_d  = cfg_data_i;
        fshp_pkg::CFG_BIAS:          bias_d = cfg_data_i;
        default: ;
      endcase
      red_busy_d = 1'b1;
      red_cnt_d  = fshp_pkg::RedCntW'(fshp_pkg::PosW - 1);
      red_pos_d  = '0;
      red_bias_d = '0;
    end
  end

  // single pass over the held word
  always_comb begin
    phase_d      = phase_q;
    hom_left_d   = hom_left_q;
    steps_left_d = steps_left_q;
    deferred_d   = deferred_q;
    pos_d        = pos_q;
    pos_mod_d    = pos_mod_q;
    prev_sw_d    = prev_sw_q;
    res_pulse_d  = 1'b0;
    res_rel_d    = 1'b0;
    res_rej_d    = 1'b0;

    card_pitch = fshp_pkg::PosW'(rev / fshp_pkg::Cards);
    card_one   = fshp_pkg::IdxW'(idx_q % fshp_pkg::Cards);
    card_prod  = (2*fshp_pkg::PosW)'(card_pitch) * (2*fshp_pkg::PosW)'(card_one);
    // the card offset stays below rev, so one subtract reduces the sum
    tgt_sum   = {1'b0, bias_mod_q} + {1'b0, card_prod[fshp_pkg::PosW-1:0]};
    if (tgt_sum >= {1'b0, rev}) begin
      tgt_sum = tgt_sum - {1'b0, rev};
    end
    target  = tgt_sum[fshp_pkg::PosW-1:0];
    fwd_gap = (target >= pos_mod_q) ? (target - pos_mod_q) : (target + rev - pos_mod_q);

    pm_inc  = {1'b0, pos_mod_q} + fshp_pkg::StepW'(1);
    pos_nxt = (pm_inc == {1'b0, rev}) ? '0 : pm_inc[fshp_pkg::PosW-1:0];
    hom_dec = (hom_left_q != '0) ? (hom_left_q - fshp_pkg::HomW'(1)) : '0;
    step_dec = (steps_left_q != '0) ? (steps_left_q - fshp_pkg::StepW'(1)) : '0;

    if (proc) begin
      case (fshp_pkg::action_e'(act_q))
        fshp_pkg::ACT_TICK: begin
          case (phase_q)
            fshp_pkg::PH_HOMING: begin
              res_pulse_d = 1'b1;
              // released to pressed: zero the position and count the homing off
              if (prev_sw_q && !lvl_q) begin
                pos_d      = '0;
                pos_mod_d  = '0;
                hom_left_d = hom_dec;
                if (hom_dec == '0) begin
                  if (deferred_q == '0) begin
                    phase_d      = fshp_pkg::PH_IDLE;
                    steps_left_d = '0;
                    res_rel_d    = 1'b1;
                  end else begin
                    phase_d      = fshp_pkg::PH_STEPPING;
                    steps_left_d = deferred_q;
                  end
                end
              end
              prev_sw_d = lvl_q;
            end
            fshp_pkg::PH_STEPPING: begin
              res_pulse_d  = 1'b1;
              pos_d        = pos_nxt;
              pos_mod_d    = pos_nxt;
              steps_left_d = step_dec;
              if (step_dec == '0) begin
                phase_d   = fshp_pkg::PH_IDLE;
                res_rel_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
        fshp_pkg::ACT_MOVE: begin
          if (phase_q != fshp_pkg::PH_IDLE) begin
            res_rej_d = 1'b1;
          end else if ({1'b0, idx_q} < fshp_pkg::CardsV) begin
            deferred_d = '0;
            if (fwd_gap == '0) begin
              steps_left_d = '0;
              res_rel_d    = 1'b1;
            end else begin
              steps_left_d = fshp_pkg::StepW'(fwd_gap);
              phase_d      = fshp_pkg::PH_STEPPING;
            end
          end else begin
            // home index/CARDS times, then step the pre-homing sum
            hom_left_d = fshp_pkg::HomW'(idx_q / fshp_pkg::Cards);
            deferred_d = fshp_pkg::StepW'(pos_mod_q) + fshp_pkg::StepW'(fwd_gap);
            phase_d    = fshp_pkg::PH_HOMING;
          end
        end
        fshp_pkg::ACT_HOME: begin
          if (phase_q != fshp_pkg::PH_IDLE) begin
            res_rej_d = 1'b1;
          end else begin
            hom_left_d = fshp_pkg::HomW'(1);
            deferred_d = fshp_pkg::StepW'(bias_mod_q);
            phase_d    = fshp_pkg::PH_HOMING;
          end
        end
        default: ;
      endcase
    end

    // the reduction pass rewrites the position copy
    if (red_busy_q && red_cnt_q == '0) begin
      pos_mod_d = rp_sh[fshp_pkg::PosW-1:0];
    end

    res_busy_d = (phase_d != fshp_pkg::PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spr_q        <= fshp_pkg::RevReset;
      bias_q       <= '0;
      pos_mod_q    <= '0;
      bias_mod_q   <= '0;
      red_busy_q   <= 1'b0;
      red_cnt_q    <= '0;
      phase_q      <= fshp_pkg::PH_IDLE;
      hom_left_q   <= '0;
      steps_left_q <= '0;
      deferred_q   <= '0;
      pos_q        <= '0;
      prev_sw_q    <= 1'b1;
      in_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      spr_q        <= spr_d;
      bias_q       <= bias_d;
      pos_mod_q    <= pos_mod_d;
      bias_mod_q   <= bias_mod_d;
      red_busy_q   <= red_busy_d;
      red_cnt_q    <= red_cnt_d;
      phase_q      <= phase_d;
      hom_left_q   <= hom_left_d;
      steps_left_q <= steps_left_d;
      deferred_q   <= deferred_d;
      pos_q        <= pos_d;
      prev_sw_q    <= prev_sw_d;
      in_vld_q     <= in_vld_d;
      out_vld_q    <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    red_pos_q  <= red_pos_d;
    red_bias_q <= red_bias_d;
    if (in_acc) begin
      act_q <= action_i;
      idx_q <= target_index_i;
      lvl_q <= switch_level_i;
    end
    if (proc) begin
      res_pulse_q <= res_pulse_d;
      res_rel_q   <= res_rel_d;
      res_busy_q  <= res_busy_d;
      res_pos_q   <= pos_d;
      res_rej_q   <= res_rej_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign step_pulse_o    = res_pulse_q;
  assign coils_release_o = res_rel_q;
  assign busy_res_o      = res_busy_q;
  assign position_o      = res_pos_q;
  assign rejected_o      = res_rej_q;

endmodule

### rtl/fshp_checker.sv
// Port-level checker for the flap stepper homing positioner core, and its bind.
// Depends on fshp_pkg for field widths.
module fshp_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_stall_i,
  input logic                      step_pulse_i,
  input logic                      coils_release_i,
  input logic                      busy_res_i,
  input logic [fshp_pkg::PosW-1:0] position_i,
  input logic                      rejected_i
);

  // a dropped command neither steps nor ends a job
  a_rej_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && rejected_i |-> !step_pulse_i && !coils_release_i)
    else $error("rejected word carries a step or a release");

  // coils go off only when nothing remains
  a_rel_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && coils_release_i |-> !busy_res_i)
    else $error("release flagged while still busy");

  // a rejection can only happen while a job runs
  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && rejected_i |-> busy_res_i)
    else $error("rejected word shows no job running");

  // the position never reaches the all-ones code
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> position_i != {fshp_pkg::PosW{1'b1}})
    else $error("position out of range");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(position_i))
    else $error("stalled result changed");

endmodule

bind flap_stepper_homing_positioner_core fshp_checker u_fshp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .step_pulse_i    (step_pulse_o),
  .coils_release_i (coils_release_o),
  .busy_res_i      (busy_res_o),
  .position_i      (position_o),
  .rejected_i      (rejected_o)
);

### verif/flap_stepper_homing_positioner_core_tb.sv
// Self-checking testbench for flap_stepper_homing_positioner_core.
// Holds its own drum predictor, a directed opening table and randomised command runs.
// Depends on fshp_pkg and the core RTL only.
module flap_stepper_homing_positioner_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HalfPeriod  = 10;
  localparam int ResetCycles = 8;
  // wait after the last result before a register write, with a little slack
  localparam int SettleCycles = 4;
  localparam int TailCycles   = 8;
  localparam int PhaseCount   = 6;
  localparam int PerPhase     = 98;
  localparam int TimeLimit    = 4_000_000;
  localparam int IdleLow      = 35;
  localparam int IdleHigh     = 52;

  // the action code that the block has no use for
  localparam logic [fshp_pkg::ActW-1:0] ActSpare = 2'd3;

  // one result word as the block reports it
  typedef struct packed {
    logic                      step_pulse;
    logic                      coils_release;
    logic                      busy_res;
    logic [fshp_pkg::PosW-1:0] position;
    logic                      rejected;
  } drum_report_t;

  // one row of the opening table: either a register write or an input word
  typedef struct {
    bit                        is_reg;
    fshp_pkg::cfg_idx_e        sel;
    logic [fshp_pkg::PosW-1:0] val;
    logic [fshp_pkg::ActW-1:0] act;
    logic [fshp_pkg::IdxW-1:0] idx;
    logic                      lvl;
    bit                        typed;
    drum_report_t              want;
  } opening_row_t;

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         in_valid_i     = 1'b0;
  logic                         in_stall_o;
  logic [fshp_pkg::ActW-1:0]    action_i       = fshp_pkg::ACT_TICK;
  logic [fshp_pkg::IdxW-1:0]    target_index_i = '0;
  logic                         switch_level_i = 1'b1;
  logic                         out_valid_o;
  logic                         out_stall_i    = 1'b0;
  logic                         step_pulse_o;
  logic                         coils_release_o;
  logic                         busy_res_o;
  logic [fshp_pkg::PosW-1:0]    position_o;
  logic                         rejected_o;
  logic                         cfg_valid_i    = 1'b0;
  logic                         cfg_ready_o;
  logic [fshp_pkg::CfgIdxW-1:0] cfg_index_i    = '0;
  logic [fshp_pkg::PosW-1:0]    cfg_data_i     = '0;

  // predicted drum state and register copies
  fshp_pkg::phase_e             drum_phase;
  logic [fshp_pkg::HomW-1:0]    homings_to_go;
  logic [fshp_pkg::StepW-1:0]   steps_to_go;
  logic [fshp_pkg::StepW-1:0]   deferred;
  logic [fshp_pkg::PosW-1:0]    drum_pos;
  logic                         last_switch;
  logic [fshp_pkg::PosW-1:0]    rev_steps;
  logic [fshp_pkg::PosW-1:0]    bias_steps;

  drum_report_t        drum_reports_q[$];
  opening_row_t        opening_rows[$];

  int unsigned         gap_pct   = IdleLow;
  int unsigned         stall_pct = IdleHigh;
  int                  errors    = 0;
  int                  n_words, n_moves, n_homes, n_rejects, n_steps, n_releases, n_settings;

  always #(HalfPeriod) clk_i = ~clk_i;

  flap_stepper_homing_positioner_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .target_index_i  (target_index_i),
    .switch_level_i  (switch_level_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .step_pulse_o    (step_pulse_o),
    .coils_release_o (coils_release_o),
    .busy_res_o      (busy_res_o),
    .position_o      (position_o),
    .rejected_o      (rejected_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  function automatic drum_report_t report_of(logic pulse, logic rel, logic busy,
                                             logic [fshp_pkg::PosW-1:0] pos, logic rej);
    drum_report_t r;
    r.step_pulse    = pulse;
    r.coils_release = rel;
    r.busy_res      = busy;
    r.position      = pos;
    r.rejected      = rej;
    return r;
  endfunction

  // End the job when nothing is left to step, else start stepping. High when done.
  function automatic logic start_run(input int n);
    if (n == 0) begin
      drum_phase  = fshp_pkg::PH_IDLE;
      steps_to_go = '0;
      return 1'b1;
    end
    steps_to_go = fshp_pkg::StepW'(n);
    drum_phase  = fshp_pkg::PH_STEPPING;
    return 1'b0;
  endfunction

  // Advance the predicted drum by one accepted word and return the word it reports.
  function automatic drum_report_t turn_drum(input logic [fshp_pkg::ActW-1:0] act,
                                             input logic [fshp_pkg::IdxW-1:0] idx,
                                             input logic lvl);
    drum_report_t r;
    int rev, pm, card_pitch, target, fwd_gap;
    r   = '0;
    // a revolution shorter than the minimum counts as the minimum
    rev = (rev_steps < fshp_pkg::MinRev) ? int'(fshp_pkg::MinRev) : int'(rev_steps);
    case (act)
      fshp_pkg::ACT_TICK: begin
        if (drum_phase == fshp_pkg::PH_HOMING) begin
          r.step_pulse = 1'b1;
          // released-to-pressed edge zeroes the drum and counts off one homing
          if (last_switch && !lvl) begin
            drum_pos = '0;
            if (homings_to_go != '0) homings_to_go--;
            if (homings_to_go == '0) r.coils_release = start_run(int'(deferred));
          end
          last_switch = lvl;
        end else if (drum_phase == fshp_pkg::PH_STEPPING) begin
          r.step_pulse = 1'b1;
          drum_pos = fshp_pkg::PosW'((int'(drum_pos) % rev + 1) % rev);
          if (steps_to_go != '0) steps_to_go--;
          if (steps_to_go == '0) begin
            drum_phase      = fshp_pkg::PH_IDLE;
            r.coils_release = 1'b1;
          end
        end
      end
      fshp_pkg::ACT_MOVE, fshp_pkg::ACT_HOME: begin
        if (drum_phase != fshp_pkg::PH_IDLE) begin
          r.rejected = 1'b1;
        end else if (act == fshp_pkg::ACT_HOME) begin
          homings_to_go = fshp_pkg::HomW'(1);
          deferred      = fshp_pkg::StepW'(int'(bias_steps) % rev);
          drum_phase    = fshp_pkg::PH_HOMING;
        end else begin
          pm         = int'(drum_pos) % rev;
          card_pitch = rev / fshp_pkg::Cards;
          target     = (int'(bias_steps) + card_pitch * (int'(idx) % fshp_pkg::Cards)) % rev;
          fwd_gap    = (target >= pm) ? target - pm : target + rev - pm;
          if (int'(idx) < fshp_pkg::Cards) begin
            deferred        = '0;
            r.coils_release = start_run(fwd_gap);
          end else begin
            homings_to_go = fshp_pkg::HomW'(int'(idx) / fshp_pkg::Cards);
            deferred      = fshp_pkg::StepW'(pm + fwd_gap);
            drum_phase    = fshp_pkg::PH_HOMING;
          end
        end
      end
      default: ;
    endcase
    r.busy_res = (drum_phase != fshp_pkg::PH_IDLE);
    r.position = drum_pos;
    return r;
  endfunction

  function automatic void plan_word(logic [fshp_pkg::ActW-1:0] act,
                                    logic [fshp_pkg::IdxW-1:0] idx, logic lvl,
                                    bit typed = 1'b0, drum_report_t want = '0);
    opening_row_t row;
    row.is_reg = 1'b0;
    row.sel    = fshp_pkg::CFG_STEPS_PER_REV;
    row.val    = '0;
    row.act    = act;
    row.idx    = idx;
    row.lvl    = lvl;
    row.typed  = typed;
    row.want   = want;
    opening_rows.push_back(row);
  endfunction

  function automatic void plan_reg(fshp_pkg::cfg_idx_e sel, logic [fshp_pkg::PosW-1:0] val);
    opening_row_t row;
    row.is_reg = 1'b1;
    row.sel    = sel;
    row.val    = val;
    row.act    = fshp_pkg::ACT_TICK;
    row.idx    = '0;
    row.lvl    = 1'b1;
    row.typed  = 1'b0;
    row.want   = '0;
    opening_rows.push_back(row);
  endfunction

  // Offer one word, hold it until taken, then log what the drum should report.
  task automatic send_word(input logic [fshp_pkg::ActW-1:0] act,
                           input logic [fshp_pkg::IdxW-1:0] idx,
                           input logic lvl, input bit typed = 1'b0,
                           input drum_report_t want = '0);
    drum_report_t predicted;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    target_index_i <= idx;
    switch_level_i <= lvl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = turn_drum(act, idx, lvl);
    drum_reports_q.push_back(typed ? want : predicted);
    n_words++;
    if (act == fshp_pkg::ACT_MOVE) n_moves++;
    if (act == fshp_pkg::ACT_HOME) n_homes++;
    n_rejects  += predicted.rejected;
    n_steps    += predicted.step_pulse;
    n_releases += predicted.coils_release;
  endtask

  // Write one register once every result word is home and the block has settled.
  task automatic write_reg(input fshp_pkg::cfg_idx_e sel,
                           input logic [fshp_pkg::PosW-1:0] val);
    in_valid_i <= 1'b0;
    while (drum_reports_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (sel == fshp_pkg::CFG_STEPS_PER_REV) rev_steps = val;
    else bias_steps = val;
    n_settings++;
  endtask

  task automatic check_field(input string name, input logic [fshp_pkg::PosW-1:0] want,
                             input logic [fshp_pkg::PosW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Compare every result word taken with the oldest one predicted; drive the
  // receiver's stall for the next cycle.
  always @(posedge clk_i) begin : result_check
    drum_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (drum_reports_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        want = drum_reports_q.pop_front();
        check_field("step_pulse",    fshp_pkg::PosW'(want.step_pulse),
                    fshp_pkg::PosW'(step_pulse_o));
        check_field("coils_release", fshp_pkg::PosW'(want.coils_release),
                    fshp_pkg::PosW'(coils_release_o));
        check_field("busy_res",      fshp_pkg::PosW'(want.busy_res),
                    fshp_pkg::PosW'(busy_res_o));
        check_field("position",      want.position, position_o);
        check_field("rejected",      fshp_pkg::PosW'(want.rejected),
                    fshp_pkg::PosW'(rejected_o));
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin : stimulus
    opening_row_t              row;
    logic [fshp_pkg::ActW-1:0] act;
    logic [fshp_pkg::IdxW-1:0] idx;
    logic                      lvl;
    logic [fshp_pkg::PosW-1:0] spr, bias;
    int unsigned               roll;
    int                        counted;
    bit                        ignored;

    // predictor starts from the reset state
    rev_steps     = fshp_pkg::RevReset;
    bias_steps    = '0;
    drum_phase    = fshp_pkg::PH_IDLE;
    homings_to_go = '0;
    steps_to_go   = '0;
    deferred      = '0;
    drum_pos      = '0;
    last_switch   = 1'b1;

    // Opening table. Reset registers first: idle tick, spare action, zero-distance move.
    plan_word(fshp_pkg::ACT_TICK, 8'd0,   1'b0, 1'b1, report_of(1'b0, 1'b0, 1'b0, '0, 1'b0));
    plan_word(ActSpare,           8'd255, 1'b1, 1'b1, report_of(1'b0, 1'b0, 1'b0, '0, 1'b0));
    plan_word(fshp_pkg::ACT_MOVE, 8'd0,   1'b1, 1'b1, report_of(1'b0, 1'b1, 1'b0, '0, 1'b0));
    // shorten the drum so jobs finish within a few ticks
    plan_reg(fshp_pkg::CFG_STEPS_PER_REV, fshp_pkg::PosW'(128));
    plan_reg(fshp_pkg::CFG_BIAS, fshp_pkg::PosW'(2));
    // move to card one, then try both commands while it runs
    plan_word(fshp_pkg::ACT_MOVE, 8'd1,   1'b1);
    plan_word(fshp_pkg::ACT_MOVE, 8'd63,  1'b0, 1'b1, report_of(1'b0, 1'b0, 1'b1, '0, 1'b1));
    plan_word(fshp_pkg::ACT_HOME, 8'd0,   1'b1, 1'b1, report_of(1'b0, 1'b0, 1'b1, '0, 1'b1));
    repeat (4) plan_word(fshp_pkg::ACT_TICK, 8'd0, 1'b1);
    // index above the card count: three homings; the stale released switch
    // gives an edge on the very first homing tick, a held-low level does not
    plan_word(fshp_pkg::ACT_MOVE, 8'd193, 1'b1);
    plan_word(fshp_pkg::ACT_TICK, 8'd0,   1'b0);
    plan_word(fshp_pkg::ACT_TICK, 8'd0,   1'b0);
    plan_word(fshp_pkg::ACT_TICK, 8'd0,   1'b1);
    plan_word(fshp_pkg::ACT_TICK, 8'd0,   1'b0);
    plan_word(fshp_pkg::ACT_TICK, 8'd0,   1'b1);
    plan_word(fshp_pkg::ACT_TICK, 8'd0,   1'b0);
    repeat (4) plan_word(fshp_pkg::ACT_TICK, 8'hff, 1'b1);
    // home once, then step the bias
    plan_word(fshp_pkg::ACT_HOME, 8'd0,   1'b1);
    plan_word(fshp_pkg::ACT_TICK, 8'd0,   1'b0);
    plan_word(fshp_pkg::ACT_TICK, 8'd0,   1'b1);
    plan_word(fshp_pkg::ACT_TICK, 8'd0,   1'b0);
    plan_word(fshp_pkg::ACT_TICK, 8'd0,   1'b1);
    plan_word(fshp_pkg::ACT_TICK, 8'd0,   1'b0);

    // hold reset, then release it on a clock edge
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening_rows[i]) begin
      row = opening_rows[i];
      if (row.is_reg) write_reg(row.sel, row.val);
      else send_word(row.act, row.idx, row.lvl, row.typed, row.want);
    end

    // Random runs: each phase picks registers and an idling pattern.
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: begin spr = '0;                                      bias = '1; end
        1: begin spr = fshp_pkg::PosW'(64);                     bias = fshp_pkg::PosW'(63); end
        2: begin spr = fshp_pkg::PosW'($urandom_range(4, 20));  bias = fshp_pkg::PosW'($urandom); end
        3: begin spr = fshp_pkg::PosW'($urandom_range(64, 200)); bias = fshp_pkg::PosW'($urandom); end
        4: begin spr = fshp_pkg::PosW'($urandom_range(0, 63));  bias = fshp_pkg::PosW'($urandom); end
        default: begin spr = '1;                                bias = '1; end
      endcase
      // sender idles less than the receiver, then the other way round, then neither
      gap_pct   = (p < 2) ? IdleLow : (p < 4) ? IdleHigh : 0;
      stall_pct = (p < 2) ? IdleHigh : (p < 4) ? IdleLow : 0;
      write_reg(fshp_pkg::CFG_STEPS_PER_REV, spr);
      write_reg(fshp_pkg::CFG_BIAS, bias);

      counted = 0;
      while (counted < PerPhase) begin
        roll = $urandom_range(0, 99);
        idx  = fshp_pkg::IdxW'($urandom);
        lvl  = 1'($urandom);
        if (drum_phase == fshp_pkg::PH_IDLE) begin
          // idle drum: mostly start a job, favouring small card indexes
          if (roll < 45) begin
            act = fshp_pkg::ACT_MOVE;
            idx = ($urandom_range(0, 3) == 0) ? fshp_pkg::IdxW'($urandom_range(64, 255))
                                              : fshp_pkg::IdxW'($urandom_range(0, 63));
          end else if (roll < 65) act = fshp_pkg::ACT_HOME;
          else if (roll < 90) act = fshp_pkg::ACT_TICK;
          else act = ActSpare;
        end else begin
          // busy drum: mostly run the job, now and then a stray command
          if (roll < 92) act = fshp_pkg::ACT_TICK;
          else if (roll < 97) act = (roll[0]) ? fshp_pkg::ACT_HOME : fshp_pkg::ACT_MOVE;
          else act = ActSpare;
        end
        ignored = (act == ActSpare) ||
                  (act == fshp_pkg::ACT_TICK && drum_phase == fshp_pkg::PH_IDLE);
        send_word(act, idx, lvl);
        if (!ignored) counted++;
      end
    end

    // drop valid and wait for the last result words to drain
    in_valid_i <= 1'b0;
    while (drum_reports_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Ran %0d words over %0d register settings: %0d moves, %0d homes, %0d refused.",
             n_words, n_settings, n_moves, n_homes, n_rejects);
    $display("Checked %0d motor steps and %0d coil releases against the drum predictor.",
             n_steps, n_releases);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // stop a hung run
  initial begin : watchdog
    #(TimeLimit);
    $display("Verification failed");
    $finish;
  end

endmodule

### files.f
rtl/fshp_pkg.sv
rtl/flap_stepper_homing_positioner_core.sv
rtl/fshp_checker.sv
verif/flap_stepper_homing_positioner_core_tb.sv
